// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define CHK_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/stamf_pkg.sv =====
// Package: types and constants of the step-aware trimmed mean filter.
package stamf_pkg;

   localparam int WINDOW_MAX_DEF = 256;
   localparam int SAMPLE_W       = 24;
   localparam int THR_W          = 23;
   localparam int STEP_CNT_W     = 9;
   localparam int TRIM_W         = 7;
   localparam int CSR_IDX_W      = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_THRESHOLD = 2'd0,
      CSR_STEP_COUNT     = 2'd1,
      CSR_TRIM_COUNT     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] reference;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] result;
      logic                       step_detected;
      logic                       error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_CLOSE,
      ST_SUM,
      ST_DIV
   } stamf_state_type;

endpackage

// ===== design/stamf_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module stamf_div import stamf_pkg::*; #(
   parameter int DVD_W = 33,
   parameter int DVS_W = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DVD_W-1:0] dividend,
   input  logic        [DVS_W-1:0] divisor,
   output logic                    done,
   output logic signed [DVD_W-1:0] quotient
);

   localparam int CW = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [DVD_W-1:0] q_ff, q_in;
   logic [DVS_W:0]   rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   rem_sh;
   logic             ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff[DVS_W-1:0], q_ff[DVD_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DVD_W);
         neg_in  = dividend[DVD_W-1];
         q_in    = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         q_in   = {q_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule

// ===== design/step_aware_trimmed_mean_filter.sv =====
// Top level: sorted-window store, insertion and summing sequencer, step tracking.
//
//   channel | ports                      | handshake
//   --------+----------------------------+--------------------------------
//   input   | start, busy, req_data      | taken when start & !busy
//   result  | rsp_valid, rsp_data        | one-cycle strobe, never stalled
//   config  | csr_we, csr_index, csr_wdata | written when csr_we is high
//
// A sample is placed by an insertion walk over the entries above it, one read and one
// compare per entry moved.
// A closing sample then sums the kept entries, or takes the step run's sum, and divides.
// Synchronous active-high reset; the store needs no clearing pass.
// busy is high while an item is at work; results cannot be held off.
module step_aware_trimmed_mean_filter import stamf_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [THR_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W = $clog2(WINDOW_MAX);
   localparam int SUM_W = SAMPLE_W + IDX_W + 1;
   localparam int KW    = ((CNT_W > STEP_CNT_W) ? CNT_W : STEP_CNT_W) + 2;

   // configuration
   logic [THR_W-1:0]      thr_ff;
   logic [STEP_CNT_W-1:0] stepc_ff;
   logic [TRIM_W-1:0]     trim_ff;

   // window state
   stamf_state_type            state_ff, state_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic signed [SAMPLE_W-1:0] href_ff, href_in;
   logic [CNT_W-1:0]           rlen_ff, rlen_in;
   logic                       rabove_ff, rabove_in;
   logic signed [SUM_W-1:0]    rsum_ff, rsum_in;
   logic                       rbroken_ff, rbroken_in;
   logic                       ovf_ff, ovf_in;

   // per-item work registers
   logic signed [SAMPLE_W-1:0] samp_ff, samp_in;
   logic                       last_ff, last_in;
   logic [CNT_W-1:0]           pos_ff, pos_in;
   logic [CNT_W-1:0]           ptr_ff, ptr_in;
   logic [CNT_W-1:0]           end_ff, end_in;
   logic                       pend_ff, pend_in;
   logic signed [SUM_W-1:0]    acc_ff, acc_in;

   // result
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // memory
   logic signed [SAMPLE_W-1:0] mem [WINDOW_MAX];
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic [IDX_W-1:0]           ra, wa;
   logic signed [SAMPLE_W-1:0] wd;
   logic                       we;

   // divider
   logic                    div_start, div_done;
   logic signed [SUM_W-1:0] div_dvd, div_q;
   logic [CNT_W-1:0]        div_dvs;

   // step check on the incoming sample
   logic signed [SAMPLE_W-1:0] ref_eff;
   logic signed [SAMPLE_W:0]   diff;
   logic [SAMPLE_W:0]          mag;
   logic                       above, accept;
   logic signed [KW-1:0]       keep;

   assign accept  = start && (state_ff == ST_IDLE);
   assign ref_eff = (fill_ff == '0 && !ovf_ff) ? req_data.reference : href_ff;
   assign diff    = {req_data.sample[SAMPLE_W-1], req_data.sample}
                    - {ref_eff[SAMPLE_W-1], ref_eff};
   assign mag     = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
   assign above   = req_data.sample > ref_eff;
   assign keep    = $signed(KW'(fill_ff)) - $signed(KW'({trim_ff, 1'b0}));

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      href_in      = href_ff;
      rlen_in      = rlen_ff;
      rabove_in    = rabove_ff;
      rsum_in      = rsum_ff;
      rbroken_in   = rbroken_ff;
      ovf_in       = ovf_ff;
      samp_in      = samp_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      pend_in      = 1'b0;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ra           = '0;
      wa           = pos_ff[IDX_W-1:0];
      wd           = samp_ff;
      we           = 1'b0;
      div_start    = 1'b0;
      div_dvd      = rsum_ff;
      div_dvs      = rlen_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               samp_in = req_data.sample;
               last_in = req_data.last;
               href_in = ref_eff;
               if (fill_ff >= CNT_W'(WINDOW_MAX)) begin
                  ovf_in   = 1'b1;
                  state_in = req_data.last ? ST_CLOSE : ST_IDLE;
               end else begin
                  if (thr_ff != '0 && KW'(fill_ff) < KW'(stepc_ff) && !rbroken_ff) begin
                     if (mag <= (SAMPLE_W+1)'(thr_ff)) begin
                        rbroken_in = 1'b1;
                     end else if (rlen_ff == '0) begin
                        rabove_in = above;
                        rlen_in   = CNT_W'(1);
                        rsum_in   = SUM_W'(req_data.sample);
                     end else if (above == rabove_ff) begin
                        rlen_in = rlen_ff + 1'b1;
                        rsum_in = rsum_ff + SUM_W'(req_data.sample);
                     end else begin
                        rbroken_in = 1'b1;
                     end
                  end
                  pos_in   = fill_ff;
                  fill_in  = fill_ff + 1'b1;
                  state_in = ST_INS_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (pos_ff == '0) begin
               we       = 1'b1;
               state_in = last_ff ? ST_CLOSE : ST_IDLE;
            end else begin
               ra       = IDX_W'(pos_ff - 1'b1);
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            we = 1'b1;
            if (rd_ff > samp_ff) begin
               wd       = rd_ff;
               pos_in   = pos_ff - 1'b1;
               state_in = ST_INS_RD;
            end else begin
               state_in = last_ff ? ST_CLOSE : ST_IDLE;
            end
         end
         ST_CLOSE: begin
            rsp_in.result        = '0;
            rsp_in.step_detected = 1'b0;
            rsp_in.error         = 1'b1;
            if (ovf_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (!rbroken_ff && KW'(rlen_ff) >= KW'(stepc_ff)) begin
               if (rlen_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  div_start            = 1'b1;
                  rsp_in.step_detected = 1'b1;
                  state_in             = ST_DIV;
               end
            end else if (keep <= 0) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               ptr_in   = CNT_W'(trim_ff);
               end_in   = fill_ff - CNT_W'(trim_ff);
               acc_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // reads issue one a cycle; data lands in the cycle after the read
            if (ptr_ff < end_ff) begin
               ra      = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               acc_in = acc_ff + SUM_W'(rd_ff);
            end
            if (!(ptr_ff < end_ff) && !pend_ff) begin
               div_start            = 1'b1;
               div_dvd              = acc_ff;
               // kept entries: (fill - trim) - trim
               div_dvs              = end_ff - CNT_W'(trim_ff);
               rsp_in.step_detected = 1'b0;
               state_in             = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_in.result = div_q[SAMPLE_W-1:0];
               rsp_in.error  = 1'b0;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_valid_in) begin
         fill_in    = '0;
         href_in    = '0;
         rlen_in    = '0;
         rabove_in  = 1'b0;
         rsum_in    = '0;
         rbroken_in = 1'b0;
         ovf_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         href_ff      <= '0;
         rlen_ff      <= '0;
         rabove_ff    <= 1'b0;
         rsum_ff      <= '0;
         rbroken_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         href_ff      <= href_in;
         rlen_ff      <= rlen_in;
         rabove_ff    <= rabove_in;
         rsum_ff      <= rsum_in;
         rbroken_ff   <= rbroken_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      samp_ff <= samp_in;
      last_ff <= last_in;
      pos_ff  <= pos_in;
      ptr_ff  <= ptr_in;
      end_ff  <= end_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= '0;
         stepc_ff <= STEP_CNT_W'(1);
         trim_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_THRESHOLD: thr_ff   <= csr_wdata;
            CSR_STEP_COUNT:     stepc_ff <= csr_wdata[STEP_CNT_W-1:0];
            CSR_TRIM_COUNT:     trim_ff  <= csr_wdata[TRIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   stamf_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/stamf_checker.sv =====
// Port checker for the trimmed mean filter, bound to the top level.
`include "assert_macros.svh"

module stamf_checker import stamf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   `CHK_SAME(a_err_zero, clock, reset, rsp_valid && rsp_data.error, rsp_data.result == '0 && !rsp_data.step_detected, "error beat carries data")
   `CHK_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy, "result beat while busy")
   `CHK_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result beats back to back")
   `CHK_SAME(a_rsp_after_work, clock, reset, rsp_valid, $past(busy) || $past(start), "result beat without work")

endmodule

bind step_aware_trimmed_mean_filter stamf_checker u_stamf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
